@@ design/mer_pkg.sv @@
// shared types, constants and microcode rom of the midpoint ellipse rasterizer
package mer_pkg;

  localparam int RADIUS_BITS_DEF = 10;
  localparam int COORD_BITS_DEF  = 12;
  localparam int PIX_BITS        = 14;
  localparam int OUT_DATA_W      = 32;
  localparam int UPC_W           = 5;

  typedef logic [UPC_W-1:0] upc_t;

  // configuration register indexes
  localparam logic REG_CENTER_X = 1'b0;
  localparam logic REG_CENTER_Y = 1'b1;

  // input item kinds
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // datapath actions, one per control word
  typedef enum logic [4:0] {
    ACT_NOP,
    ACT_WAIT,
    ACT_EMIT,
    ACT_LD_RX2,
    ACT_LD_RY2,
    ACT_START_ACC,
    ACT_START_FIN,
    ACT_X_INC,
    ACT_Y_DEC,
    ACT_D_R1_POS,
    ACT_D_R1_NEG,
    ACT_SET_R2,
    ACT_LD_MTMP,
    ACT_ACC_LD,
    ACT_ACC_ADD4,
    ACT_ACC_SUB4,
    ACT_D_RND,
    ACT_D_R2_POS,
    ACT_D_R2_NEG
  } act_t;

  // multiplier operand sources
  typedef enum logic [2:0] {
    OPD_RX,
    OPD_RY,
    OPD_RX2,
    OPD_RY2,
    OPD_X2P1,
    OPD_YM1,
    OPD_MTMP
  } opnd_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_DONE,
    COND_REGION2,
    COND_NOT_LT,
    COND_DEC_NEG,
    COND_DEC_POS
  } cond_t;

  typedef struct packed {
    act_t  act;
    opnd_t asel;
    opnd_t bsel;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // microcode addresses
  localparam upc_t UA_IDLE  = 5'd0;
  localparam upc_t UA_S0    = 5'd1;
  localparam upc_t UA_S1    = 5'd2;
  localparam upc_t UA_S2    = 5'd3;
  localparam upc_t UA_S3    = 5'd4;
  localparam upc_t UA_S4    = 5'd5;
  localparam upc_t UA_T0    = 5'd6;
  localparam upc_t UA_T1    = 5'd7;
  localparam upc_t UA_T2    = 5'd8;
  localparam upc_t UA_R1A   = 5'd9;
  localparam upc_t UA_R1B   = 5'd10;
  localparam upc_t UA_R1C   = 5'd11;
  localparam upc_t UA_R1N   = 5'd12;
  localparam upc_t UA_E0    = 5'd13;
  localparam upc_t UA_E1    = 5'd14;
  localparam upc_t UA_E2    = 5'd15;
  localparam upc_t UA_E3    = 5'd16;
  localparam upc_t UA_E4    = 5'd17;
  localparam upc_t UA_E5    = 5'd18;
  localparam upc_t UA_E6    = 5'd19;
  localparam upc_t UA_Q0    = 5'd20;
  localparam upc_t UA_Q1    = 5'd21;
  localparam upc_t UA_Q2    = 5'd22;
  localparam upc_t UA_Q3    = 5'd23;
  localparam upc_t UA_EMIT  = 5'd24;

  localparam upc_t UA_START = UA_S0;
  localparam upc_t UA_STEP  = UA_T0;

  function automatic uword_t ucode_rom(input upc_t addr);
    uword_t w;
    w = '{act: ACT_NOP, asel: OPD_RX, bsel: OPD_RX, cond: COND_NEXT, target: UA_IDLE};
    case (addr)
      UA_IDLE: w.act = ACT_WAIT;
      // start: squares, step_py and the region one start value
      UA_S0: begin
        w.asel = OPD_RX;
        w.bsel = OPD_RX;
      end
      UA_S1: begin
        w.act  = ACT_LD_RX2;
        w.asel = OPD_RY;
        w.bsel = OPD_RY;
      end
      UA_S2: begin
        w.act  = ACT_LD_RY2;
        w.asel = OPD_RX2;
        w.bsel = OPD_RY;
      end
      UA_S3: w.act = ACT_START_ACC;
      UA_S4: begin
        w.act    = ACT_START_FIN;
        w.cond   = COND_ALWAYS;
        w.target = UA_EMIT;
      end
      // step dispatch
      UA_T0: begin
        w.cond   = COND_DONE;
        w.target = UA_IDLE;
      end
      UA_T1: begin
        w.cond   = COND_REGION2;
        w.target = UA_Q0;
      end
      UA_T2: begin
        w.cond   = COND_NOT_LT;
        w.target = UA_E0;
      end
      // region one
      UA_R1A: begin
        w.act    = ACT_X_INC;
        w.cond   = COND_DEC_NEG;
        w.target = UA_R1N;
      end
      UA_R1B: w.act = ACT_Y_DEC;
      UA_R1C: begin
        w.act    = ACT_D_R1_POS;
        w.cond   = COND_ALWAYS;
        w.target = UA_EMIT;
      end
      UA_R1N: begin
        w.act    = ACT_D_R1_NEG;
        w.cond   = COND_ALWAYS;
        w.target = UA_EMIT;
      end
      // region two start value
      UA_E0: begin
        w.act  = ACT_SET_R2;
        w.asel = OPD_X2P1;
        w.bsel = OPD_X2P1;
      end
      UA_E1: begin
        w.act  = ACT_LD_MTMP;
        w.asel = OPD_YM1;
        w.bsel = OPD_YM1;
      end
      UA_E2: begin
        w.act  = ACT_LD_MTMP;
        w.asel = OPD_RY2;
        w.bsel = OPD_MTMP;
      end
      UA_E3: begin
        w.act  = ACT_ACC_LD;
        w.asel = OPD_RX2;
        w.bsel = OPD_MTMP;
      end
      UA_E4: begin
        w.act  = ACT_ACC_ADD4;
        w.asel = OPD_RX2;
        w.bsel = OPD_RY2;
      end
      UA_E5: w.act = ACT_ACC_SUB4;
      UA_E6: w.act = ACT_D_RND;
      // region two
      UA_Q0: begin
        w.act    = ACT_Y_DEC;
        w.cond   = COND_DEC_POS;
        w.target = UA_Q2;
      end
      UA_Q1: begin
        w.act    = ACT_X_INC;
        w.cond   = COND_ALWAYS;
        w.target = UA_Q3;
      end
      UA_Q2: begin
        w.act    = ACT_D_R2_POS;
        w.cond   = COND_ALWAYS;
        w.target = UA_EMIT;
      end
      UA_Q3: begin
        w.act    = ACT_D_R2_NEG;
        w.cond   = COND_ALWAYS;
        w.target = UA_EMIT;
      end
      UA_EMIT: begin
        w.act    = ACT_EMIT;
        w.target = UA_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = UA_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ design/midpoint_ellipse_rasterizer.sv @@
// midpoint ellipse rasterizer: microcoded sequencer, shared multiplier and pixel output register
//
// A start transfer (tuser 0) loads the two semi-axes and produces the four mirrored pixels of
// (0, radius_y); each step transfer (tuser 1) advances one point of the first quadrant and
// produces four pixels in the order (+x,+y) (-x,+y) (+x,-y) (-x,-y), tlast on the fourth and
// tuser on all four when the point is the final one (y reached zero). A step after the final
// point produces nothing. Control is a 25-word microcode rom stepped by a program counter; every
// cycle runs one control word, and all products go through one registered multiplier. The step
// that switches regions runs seven extra words for the region two start value. The pixel issue
// puts one pixel a cycle into the output register while it has room; back pressure stalls it.
// The next item is taken while the last pixel still waits in the output register. Centers are
// written through the apb port at byte addresses 0 (center_x) and 4 (center_y).
module midpoint_ellipse_rasterizer #(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // input items
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // radius_x, radius_y
  input  logic [((2*RADIUS_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // op
  input  logic [0:0]                               s_axis_tuser,
  // pixel output
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // pixel_x, pixel_y
  output logic [mer_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
  // last
  output logic                                     m_axis_tlast,
  // finished
  output logic [0:0]                               m_axis_tuser,
  // configuration
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [2:0]                               paddr,
  input  logic [31:0]                              pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  localparam int R       = RADIUS_BITS;
  localparam int X_W     = R + 1;          // x may pass the radius by one in region two
  localparam int SQ_W    = 2 * R;
  localparam int STEP_W  = 3 * R + 3;
  localparam int DEC_W   = 4 * R + 10;
  localparam int MUL_W   = 2 * R + 4;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SUM_W   = COORD_BITS + R + 2;
  localparam int PIX_W   = mer_pkg::PIX_BITS;
  localparam int PAD_W   = mer_pkg::OUT_DATA_W - 2 * PIX_W;

  localparam logic signed [DEC_W-1:0] TWO_D   = DEC_W'(2);
  localparam logic signed [DEC_W-1:0] THREE_D = DEC_W'(3);

  // sequencer
  mer_pkg::upc_t   upc;
  mer_pkg::upc_t   upc_next;
  mer_pkg::uword_t uw;
  logic [1:0]      pix_idx;
  logic            in_region_two;
  logic            done_flag;

  // configuration
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;

  // datapath
  logic [R-1:0]                rad_x;
  logic [R-1:0]                rad_y;
  logic [X_W-1:0]              cur_x;
  logic [R-1:0]                cur_y;
  logic [SQ_W-1:0]             rx_squared;
  logic [SQ_W-1:0]             ry_squared;
  logic [STEP_W-1:0]           step_px;
  logic [STEP_W-1:0]           step_py;
  logic signed [DEC_W-1:0]     decision;
  logic signed [DEC_W-1:0]     acc;
  logic [MUL_W-1:0]            mtmp;
  logic [PROD_W-1:0]           prod;
  logic [MUL_W-1:0]            mul_a;
  logic [MUL_W-1:0]            mul_b;

  logic                        in_xfer;
  logic                        cfg_wr;
  logic                        slot_free;
  logic                        emit_load;
  logic                        cond_hit;
  logic [R-1:0]                y_minus1;
  logic [STEP_W-1:0]           step_px_inc;
  logic [STEP_W-1:0]           step_py_dec;
  logic signed [DEC_W-1:0]     rx2_d;
  logic signed [DEC_W-1:0]     ry2_d;
  logic signed [DEC_W-1:0]     px_d;
  logic signed [DEC_W-1:0]     py_d;
  logic signed [DEC_W-1:0]     prod_d;
  logic signed [DEC_W-1:0]     acc_rnd;
  logic [SUM_W-1:0]            sum_x;
  logic [SUM_W-1:0]            sum_y;

  assign uw            = mer_pkg::ucode_rom(upc);
  assign s_axis_tready = (uw.act == mer_pkg::ACT_WAIT);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !m_axis_tvalid || m_axis_tready;
  assign emit_load     = (uw.act == mer_pkg::ACT_EMIT) && slot_free;

  // apb: always ready, reads return the center registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == mer_pkg::REG_CENTER_Y) ? 32'(center_y) : 32'(center_x);

  // widened views for the decision arithmetic
  assign y_minus1    = cur_y - R'(1);
  assign step_px_inc = step_px + STEP_W'({ry_squared, 1'b0});
  assign step_py_dec = step_py - STEP_W'({rx_squared, 1'b0});
  assign rx2_d       = $signed(DEC_W'(rx_squared));
  assign ry2_d       = $signed(DEC_W'(ry_squared));
  assign px_d        = $signed(DEC_W'(step_px));
  assign py_d        = $signed(DEC_W'(step_py));
  assign prod_d      = $signed(DEC_W'(prod));
  // (q + 2) / 4 toward zero; the +2 is already in acc
  assign acc_rnd     = (acc[DEC_W-1] ? acc + THREE_D : acc) >>> 2;

  // jump condition
  always_comb begin
    case (uw.cond)
      mer_pkg::COND_NEXT:    cond_hit = 1'b0;
      mer_pkg::COND_ALWAYS:  cond_hit = 1'b1;
      mer_pkg::COND_DONE:    cond_hit = done_flag;
      mer_pkg::COND_REGION2: cond_hit = in_region_two;
      mer_pkg::COND_NOT_LT:  cond_hit = !(step_px < step_py);
      mer_pkg::COND_DEC_NEG: cond_hit = decision[DEC_W-1];
      mer_pkg::COND_DEC_POS: cond_hit = !decision[DEC_W-1] && (|decision);
      default:               cond_hit = 1'b0;
    endcase
  end

  // program counter
  always_comb begin
    upc_next = upc;
    case (uw.act)
      mer_pkg::ACT_WAIT: begin
        if (in_xfer) begin
          upc_next = (s_axis_tuser[0] == mer_pkg::OP_STEP) ? mer_pkg::UA_STEP
                                                            : mer_pkg::UA_START;
        end
      end
      mer_pkg::ACT_EMIT: begin
        if (emit_load && (pix_idx == 2'd3)) begin
          upc_next = uw.target;
        end
      end
      default: begin
        upc_next = cond_hit ? uw.target : upc + mer_pkg::upc_t'(1);
      end
    endcase
  end

  // multiplier operand selection
  always_comb begin
    case (uw.asel)
      mer_pkg::OPD_RX:   mul_a = MUL_W'(rad_x);
      mer_pkg::OPD_RY:   mul_a = MUL_W'(rad_y);
      mer_pkg::OPD_RX2:  mul_a = MUL_W'(rx_squared);
      mer_pkg::OPD_RY2:  mul_a = MUL_W'(ry_squared);
      mer_pkg::OPD_X2P1: mul_a = MUL_W'({cur_x, 1'b1});
      mer_pkg::OPD_YM1:  mul_a = MUL_W'(y_minus1);
      mer_pkg::OPD_MTMP: mul_a = mtmp;
      default:           mul_a = '0;
    endcase
    case (uw.bsel)
      mer_pkg::OPD_RX:   mul_b = MUL_W'(rad_x);
      mer_pkg::OPD_RY:   mul_b = MUL_W'(rad_y);
      mer_pkg::OPD_RX2:  mul_b = MUL_W'(rx_squared);
      mer_pkg::OPD_RY2:  mul_b = MUL_W'(ry_squared);
      mer_pkg::OPD_X2P1: mul_b = MUL_W'({cur_x, 1'b1});
      mer_pkg::OPD_YM1:  mul_b = MUL_W'(y_minus1);
      mer_pkg::OPD_MTMP: mul_b = mtmp;
      default:           mul_b = '0;
    endcase
  end

  // mirrored pixel for the current issue slot: bit 0 negates x, bit 1 negates y
  always_comb begin
    sum_x = pix_idx[0] ? SUM_W'(center_x) - SUM_W'(cur_x) : SUM_W'(center_x) + SUM_W'(cur_x);
    sum_y = pix_idx[1] ? SUM_W'(center_y) - SUM_W'(cur_y) : SUM_W'(center_y) + SUM_W'(cur_y);
  end

  // control state, configuration and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      upc           <= mer_pkg::UA_IDLE;
      pix_idx       <= '0;
      in_region_two <= 1'b0;
      done_flag     <= 1'b1;
      m_axis_tvalid <= 1'b0;
      center_x      <= COORD_BITS'(320);
      center_y      <= COORD_BITS'(240);
    end else begin
      upc <= upc_next;
      if (cfg_wr) begin
        if (paddr[2] == mer_pkg::REG_CENTER_X) begin
          center_x <= pwdata[COORD_BITS-1:0];
        end else begin
          center_y <= pwdata[COORD_BITS-1:0];
        end
      end
      if (uw.act == mer_pkg::ACT_START_FIN) begin
        in_region_two <= 1'b0;
      end
      if (uw.act == mer_pkg::ACT_SET_R2) begin
        in_region_two <= 1'b1;
      end
      if (emit_load) begin
        pix_idx       <= pix_idx + 2'd1;
        done_flag     <= (cur_y == '0);
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (in_xfer) begin
      rad_x <= s_axis_tdata[R-1:0];
      rad_y <= s_axis_tdata[2*R-1:R];
    end
    if (emit_load) begin
      m_axis_tdata <= {{PAD_W{1'b0}}, sum_y[PIX_W-1:0], sum_x[PIX_W-1:0]};
      m_axis_tlast <= (pix_idx == 2'd3);
      m_axis_tuser <= (cur_y == '0);
    end
    case (uw.act)
      mer_pkg::ACT_LD_RX2: rx_squared <= prod[SQ_W-1:0];
      mer_pkg::ACT_LD_RY2: ry_squared <= prod[SQ_W-1:0];
      mer_pkg::ACT_START_ACC: begin
        step_py <= STEP_W'(prod) << 1;
        acc     <= (ry2_d <<< 2) + rx2_d + TWO_D - (prod_d <<< 2);
      end
      mer_pkg::ACT_START_FIN: begin
        decision <= acc_rnd;
        cur_x    <= '0;
        cur_y    <= rad_y;
        step_px  <= '0;
      end
      mer_pkg::ACT_X_INC: begin
        cur_x   <= cur_x + X_W'(1);
        step_px <= step_px_inc;
      end
      mer_pkg::ACT_Y_DEC: begin
        cur_y   <= y_minus1;
        step_py <= step_py_dec;
      end
      mer_pkg::ACT_D_R1_POS: decision <= decision + ry2_d + px_d - py_d;
      mer_pkg::ACT_D_R1_NEG: decision <= decision + ry2_d + px_d;
      mer_pkg::ACT_LD_MTMP:  mtmp     <= prod[MUL_W-1:0];
      mer_pkg::ACT_ACC_LD:   acc      <= prod_d;
      mer_pkg::ACT_ACC_ADD4: acc      <= acc + (prod_d <<< 2);
      mer_pkg::ACT_ACC_SUB4: acc      <= acc - (prod_d <<< 2) + TWO_D;
      mer_pkg::ACT_D_RND:    decision <= acc_rnd;
      mer_pkg::ACT_D_R2_POS: decision <= decision + rx2_d - py_d;
      mer_pkg::ACT_D_R2_NEG: decision <= decision + rx2_d - py_d + px_d;
      default: ;
    endcase
  end

endmodule

@@ dv/mer_checker.sv @@
`timescale 1ns / 1ps
// pixel stream checker for the midpoint ellipse rasterizer: tracks the curve and compares pixels
module mer_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // radius_x, radius_y, zero padding
  input  logic [23:0]                    s_axis_tdata,
  // op
  input  logic [0:0]                     s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pixel_x, pixel_y, zero padding
  input  logic [mer_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // last
  input  logic                           m_axis_tlast,
  // finished
  input  logic [0:0]                     m_axis_tuser,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  input  logic                           pready,
  output int                             error_count,
  output int                             pending_pixels,
  output bit                             ellipse_done
);

  localparam int RB = mer_pkg::RADIUS_BITS_DEF;
  localparam int CB = mer_pkg::COORD_BITS_DEF;
  localparam int PB = mer_pkg::PIX_BITS;

  typedef struct packed {
    logic [PB-1:0] x;
    logic [PB-1:0] y;
    logic          last;
    logic          fin;
  } pixel_t;

  pixel_t           expected_pixels[$];
  logic [CB-1:0]    center_x;
  logic [CB-1:0]    center_y;
  longint           x_pos, y_pos, rx_sq, ry_sq, slope_x, slope_y, decision;
  bit               in_region_two;
  int               reported;

  assign pending_pixels = expected_pixels.size();

  // (int)(v + 0.5) for v held in quarter units
  function automatic longint round_quarter(longint q);
    return (q + 2) / 4;
  endfunction

  // four mirrored pixels of the current point
  task automatic plot_point();
    pixel_t p;
    longint dx, dy;
    for (int k = 0; k < 4; k++) begin
      dx = (k % 2 == 0) ? x_pos : -x_pos;
      dy = (k < 2) ? y_pos : -y_pos;
      p.x = PB'(longint'(center_x) + dx);
      p.y = PB'(longint'(center_y) + dy);
      p.last = (k == 3);
      p.fin = (y_pos == 0);
      expected_pixels.push_back(p);
    end
  endtask

  task automatic trace_item(logic op, logic [RB-1:0] rx, logic [RB-1:0] ry);
    if (op == mer_pkg::OP_START) begin
      rx_sq = longint'(rx) * longint'(rx);
      ry_sq = longint'(ry) * longint'(ry);
      x_pos = 0;
      y_pos = ry;
      slope_x = 0;
      slope_y = 2 * rx_sq * longint'(ry);
      decision = round_quarter(4 * ry_sq - 4 * rx_sq * longint'(ry) + rx_sq);
      in_region_two = 1'b0;
      ellipse_done = (y_pos == 0);
      plot_point();
    end else if (!ellipse_done) begin
      if (!in_region_two && slope_x < slope_y) begin
        x_pos++;
        slope_x += 2 * ry_sq;
        if (decision < 0) begin
          decision += ry_sq + slope_x;
        end else begin
          y_pos--;
          slope_y -= 2 * rx_sq;
          decision += ry_sq + slope_x - slope_y;
        end
      end else begin
        // first step of region two gets a fresh decision value
        if (!in_region_two) begin
          in_region_two = 1'b1;
          decision = round_quarter(ry_sq * (4 * x_pos * x_pos + 4 * x_pos + 1)
                                   + 4 * rx_sq * (y_pos - 1) * (y_pos - 1)
                                   - 4 * rx_sq * ry_sq);
        end
        y_pos--;
        slope_y -= 2 * rx_sq;
        if (decision > 0) begin
          decision += rx_sq - slope_y;
        end else begin
          x_pos++;
          slope_x += 2 * ry_sq;
          decision += rx_sq - slope_y + slope_x;
        end
      end
      ellipse_done = (y_pos == 0);
      plot_point();
    end
  endtask

  always @(posedge clk) begin
    pixel_t got, want;
    if (rst) begin
      expected_pixels.delete();
      center_x = 12'd320;
      center_y = 12'd240;
      x_pos = 0;
      y_pos = 0;
      rx_sq = 0;
      ry_sq = 0;
      slope_x = 0;
      slope_y = 0;
      decision = 0;
      in_region_two = 1'b0;
      ellipse_done = 1'b1;
      error_count = 0;
      reported = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.x = m_axis_tdata[PB-1:0];
        got.y = m_axis_tdata[2*PB-1:PB];
        got.last = m_axis_tlast;
        got.fin = m_axis_tuser[0];
        if (expected_pixels.size() == 0) begin
          error_count++;
          if (reported < 10) begin
            reported++;
            $display("unexpected pixel x=%0d y=%0d last=%0b fin=%0b", $signed(got.x),
                     $signed(got.y), got.last, got.fin);
          end
        end else begin
          want = expected_pixels.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.last !== want.last ||
              got.fin !== want.fin) begin
            error_count++;
            if (reported < 10) begin
              reported++;
              $display({"pixel mismatch: expected x=%0d y=%0d last=%0b fin=%0b, ",
                        "got x=%0d y=%0d last=%0b fin=%0b"},
                       $signed(want.x), $signed(want.y), want.last, want.fin,
                       $signed(got.x), $signed(got.y), got.last, got.fin);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        trace_item(s_axis_tuser[0], s_axis_tdata[RB-1:0], s_axis_tdata[2*RB-1:RB]);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == mer_pkg::REG_CENTER_X) center_x = pwdata[CB-1:0];
        else center_y = pwdata[CB-1:0];
      end
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// top of the rasterizer testbench: clock, reset, item and config stimulus, verdict
module tb_top;

  localparam int RB = mer_pkg::RADIUS_BITS_DEF;
  localparam int IN_DATA_W = ((2 * RB + 7) / 8) * 8;
  // region switch step is the slowest item, leave room above it
  localparam int SETTLE_CYCLES = 40;
  // ~370 items, each with its work plus four pixels under heavy stalls
  localparam int unsigned LIMIT_CYCLES = 300000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // radius_x, radius_y, zero padding
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  // op
  logic [0:0]             s_axis_tuser = mer_pkg::OP_START;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // pixel_x, pixel_y, zero padding
  logic [mer_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  // last
  logic                   m_axis_tlast;
  // finished
  logic [0:0]             m_axis_tuser;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [2:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  int                     error_count;
  int                     pending_pixels;
  bit                     ellipse_done;

  // idle rates in percent for the item sender and the pixel receiver
  int                     src_idle = 18;
  int                     sink_idle = 50;
  // items that actually move the block, ignored steps are not counted
  int                     item_count = 0;
  int unsigned            cycle_count = 0;

  always #6 clk = ~clk;

  midpoint_ellipse_rasterizer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  mer_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .m_axis_tuser   (m_axis_tuser),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .error_count    (error_count),
    .pending_pixels (pending_pixels),
    .ellipse_done   (ellipse_done)
  );

  // pixel receiver back pressure, one decision per cycle
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle);
  end

  // watchdog, covers hangs and pixels that never show up
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // one item transfer; called and returns at a falling edge
  task automatic push_item(logic op, logic [RB-1:0] rx, logic [RB-1:0] ry);
    // a step on a finished ellipse is dropped by the block, keep it out of the tally
    if (!(op == mer_pkg::OP_STEP && ellipse_done)) item_count++;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= IN_DATA_W'({ry, rx});
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // step the current ellipse until its final point or until the cap cuts it short
  task automatic trace_to_end(int cap);
    int n;
    n = 0;
    while (!ellipse_done && n < cap) begin
      push_item(mer_pkg::OP_STEP, RB'($urandom), RB'($urandom));
      n++;
    end
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // block quiet: all pixels seen, then room for a step that makes none
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one well-formed ellipse with random radii, sometimes cut short by the next start
  task automatic draw_ellipse();
    logic [RB-1:0] rx, ry;
    int cap;
    if ($urandom_range(9) == 0) begin
      // full-range radii: only a handful of points, else one curve eats the budget
      rx = RB'($urandom);
      ry = RB'($urandom);
      cap = $urandom_range(16);
    end else begin
      rx = RB'($urandom_range(12));
      ry = RB'($urandom_range(12));
      cap = ($urandom_range(5) == 0) ? $urandom_range(6) : 4096;
    end
    push_item(mer_pkg::OP_START, rx, ry);
    trace_to_end(cap);
    // a few steps past the final point now and then
    if (ellipse_done) begin
      repeat ($urandom_range(2)) push_item(mer_pkg::OP_STEP, RB'($urandom), RB'($urandom));
    end
  endtask

  task automatic run_phase(int src_pct, int sink_pct, logic [31:0] cx, logic [31:0] cy,
                           int goal);
    wait_idle();
    write_reg(mer_pkg::REG_CENTER_X, cx);
    write_reg(mer_pkg::REG_CENTER_Y, cy);
    src_idle = src_pct;
    sink_idle = sink_pct;
    goal += item_count;
    while (item_count < goal) begin
      // mostly whole curves, some loose items of either kind
      if ($urandom_range(9) == 0) push_item(1'($urandom), RB'($urandom), RB'($urandom));
      else draw_ellipse();
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, reset centers 320 / 240
    // step with nothing drawn yet
    push_item(mer_pkg::OP_STEP, '1, '1);
    // both radii zero: start point is the final one
    push_item(mer_pkg::OP_START, '0, '0);
    push_item(mer_pkg::OP_STEP, '0, '0);
    // zero vertical radius
    push_item(mer_pkg::OP_START, 10'd5, '0);
    // zero horizontal radius: straight into region two along the axis
    push_item(mer_pkg::OP_START, '0, 10'd3);
    trace_to_end(8);
    // largest radii, then a restart while drawing
    push_item(mer_pkg::OP_START, '1, '1);
    trace_to_end(2);
    // long region one with a flat ellipse
    push_item(mer_pkg::OP_START, '1, 10'd1);
    trace_to_end(3);
    // tall ellipse: region switch right away with wide products
    push_item(mer_pkg::OP_START, 10'd1, '1);
    trace_to_end(3);
    // small ellipse through both regions to its end, then a step past it
    push_item(mer_pkg::OP_START, 10'd2, 10'd3);
    trace_to_end(20);
    push_item(mer_pkg::OP_STEP, '0, '0);

    // random part: extreme centers, then the other idle mix, then no idling
    run_phase(18, 50, 32'h0000_0000, 32'hffff_f000, 105);
    run_phase(50, 18, 32'hffff_ffff, 32'h0000_0fff, 105);
    run_phase(0, 0, $urandom, $urandom, 100);

    wait_idle();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
